// File: sv/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants, types and helpers for the HSV to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

	localparam int unsigned HUE_W    = 16;
	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned FRAC_W   = 12;
	localparam int unsigned PROD_W   = 20;	// saturation * fraction, and D
	localparam int unsigned NUM_W    = 28;	// value * (D - s*f)
	localparam int unsigned QUO_W    = 16;	// numerator / 3840
	localparam int unsigned RCP_W    = 21;

	localparam logic [HUE_W-1:0]  HUE_TURN   = 16'd23040;	// 360 degrees
	localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd3840;	// 60 degrees
	localparam logic [FRAC_W-1:0] FRAC_FULL  = 12'd3840;
	localparam logic [PROD_W-1:0] FRAC_DENOM = 20'd979200;	// 255 * 3840
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

	// ceil(2^24 / 15): exact floor(y / 15) for y below 2^20
	localparam logic [RCP_W-1:0]  RECIP15    = 21'd1118482;
	localparam int unsigned       RCP_SHIFT  = 24;

	typedef enum logic [2:0] {
		SEC_0 = 3'd0,
		SEC_1 = 3'd1,
		SEC_2 = 3'd2,
		SEC_3 = 3'd3,
		SEC_4 = 3'd4,
		SEC_5 = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t             sector;
		logic [FRAC_W-1:0]   frac;		// position within the sector
		logic [FRAC_W-1:0]   frac_c;	// 3840 - frac
	} hue_split_t;

	// floor(x / 255), exact for x up to 255 * 256 - 1
	function automatic logic [CHAN_W-1:0] div255(input logic [QUO_W-1:0] x);
		logic [QUO_W:0] sum;
		sum = {1'b0, x} + {9'd0, x[QUO_W-1:8]} + 17'd1;
		return sum[QUO_W-1:8];
	endfunction

endpackage

`default_nettype wire

// File: sv/hsvrgb_hue_split.sv
// ----------------------------------------------------------------------------
// hsvrgb_hue_split
// Folds out-of-range hue to zero and splits it into sector and fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_hue_split (
	input  wire logic [hsvrgb_pkg::HUE_W-1:0] hue,
	output hsvrgb_pkg::hue_split_t             split
);

	logic [hsvrgb_pkg::HUE_W-1:0] h;
	logic [hsvrgb_pkg::HUE_W-1:0] base;
	logic [hsvrgb_pkg::HUE_W-1:0] rem;
	hsvrgb_pkg::sector_t          sec;

	assign h = (hue >= hsvrgb_pkg::HUE_TURN) ? '0 : hue;

	always_comb begin
		if (h < hsvrgb_pkg::HUE_SECTOR) begin
			sec  = hsvrgb_pkg::SEC_0;
			base = 16'd0;
		end else if (h < 16'd7680) begin
			sec  = hsvrgb_pkg::SEC_1;
			base = 16'd3840;
		end else if (h < 16'd11520) begin
			sec  = hsvrgb_pkg::SEC_2;
			base = 16'd7680;
		end else if (h < 16'd15360) begin
			sec  = hsvrgb_pkg::SEC_3;
			base = 16'd11520;
		end else if (h < 16'd19200) begin
			sec  = hsvrgb_pkg::SEC_4;
			base = 16'd15360;
		end else begin
			sec  = hsvrgb_pkg::SEC_5;
			base = 16'd19200;
		end
	end

	assign rem = h - base;

	assign split.sector = sec;
	assign split.frac   = rem[hsvrgb_pkg::FRAC_W-1:0];
	assign split.frac_c = hsvrgb_pkg::FRAC_FULL - rem[hsvrgb_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

// File: sv/hsvrgb_div_d.sv
// ----------------------------------------------------------------------------
// hsvrgb_div_d
// Divides a channel numerator by 255 * 3840: a registered reciprocal
// multiply for the /3840 part, then a shift-add /255 on the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div_d (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [hsvrgb_pkg::NUM_W-1:0]   num,
	output logic      [hsvrgb_pkg::CHAN_W-1:0]  level
);

	localparam int unsigned SHR_W = hsvrgb_pkg::NUM_W - 8;
	localparam int unsigned MUL_W = SHR_W + hsvrgb_pkg::RCP_W;

	logic [SHR_W-1:0]              num_shr;
	logic [MUL_W-1:0]              prod;
	logic [hsvrgb_pkg::QUO_W-1:0]  quo_s4;

	// /3840 = />>8 then /15
	assign num_shr = num[hsvrgb_pkg::NUM_W-1:8];
	assign prod    = MUL_W'(num_shr) * MUL_W'(hsvrgb_pkg::RECIP15);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s4 <= prod[hsvrgb_pkg::RCP_SHIFT +: hsvrgb_pkg::QUO_W];
		end
	end

	assign level = hsvrgb_pkg::div255(quo_s4);

endmodule

`default_nettype wire

// File: sv/hsv_to_rgb_converter.sv
// Each request passes the stage registers s1 to s5 in order; s5 is the output register.
// Throughput: one request per cycle; the five stages advance together and
// hold as a whole while the output register waits on out_ready.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Five-stage fixed-point HSV to RGB conversion with exact truncation.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [hsvrgb_pkg::HUE_W-1:0]   hue,
	input  wire logic [hsvrgb_pkg::CHAN_W-1:0]  saturation,
	input  wire logic [hsvrgb_pkg::CHAN_W-1:0]  brightness,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [hsvrgb_pkg::CHAN_W-1:0]  red,
	output logic      [hsvrgb_pkg::CHAN_W-1:0]  green,
	output logic      [hsvrgb_pkg::CHAN_W-1:0]  blue
);

	localparam int unsigned CW = hsvrgb_pkg::CHAN_W;
	localparam int unsigned FW = hsvrgb_pkg::FRAC_W;
	localparam int unsigned PW = hsvrgb_pkg::PROD_W;
	localparam int unsigned NW = hsvrgb_pkg::NUM_W;
	localparam int unsigned QW = hsvrgb_pkg::QUO_W;

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	hsvrgb_pkg::hue_split_t split;
	hsvrgb_pkg::hue_split_t split_s1;
	logic [CW-1:0]          sat_s1, val_s1;

	logic [PW-1:0]          gq_s2, gt_s2;
	logic [QW-1:0]          pprod_s2;
	hsvrgb_pkg::sector_t    sector_s2, sector_s3, sector_s4;
	logic [CW-1:0]          val_s2, val_s3, val_s4;

	logic [NW-1:0]          nq_s3, nt_s3;
	logic [CW-1:0]          p_s3, p_s4;

	logic [CW-1:0]          q_lvl, t_lvl;
	logic [CW-1:0]          r_nx, g_nx, b_nx;
	logic [CW-1:0]          red_s5, green_s5, blue_s5;

	// whole pipe moves unless the output holds an untaken result
	assign adv      = !valid_s5 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	hsvrgb_hue_split u_split (
		.hue   (hue),
		.split (split)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: sector and fraction
			split_s1  <= split;
			sat_s1    <= saturation;
			val_s1    <= brightness;
			// stage 2: s*f, s*(3840-f), v*(255-s)
			gq_s2     <= PW'(split_s1.frac) * PW'(sat_s1);
			gt_s2     <= PW'(split_s1.frac_c) * PW'(sat_s1);
			pprod_s2  <= QW'(val_s1) * QW'(hsvrgb_pkg::CHAN_MAX - sat_s1);
			sector_s2 <= split_s1.sector;
			val_s2    <= val_s1;
			// stage 3: v*(D - s*f) numerators, p level
			nq_s3     <= NW'(val_s2) * NW'(hsvrgb_pkg::FRAC_DENOM - gq_s2);
			nt_s3     <= NW'(val_s2) * NW'(hsvrgb_pkg::FRAC_DENOM - gt_s2);
			p_s3      <= hsvrgb_pkg::div255(pprod_s2);
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			// stage 4: quotient registers live in the dividers
			p_s4      <= p_s3;
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			// stage 5: output register
			red_s5    <= r_nx;
			green_s5  <= g_nx;
			blue_s5   <= b_nx;
		end
	end

	hsvrgb_div_d u_div_q (
		.clk   (clk),
		.en    (adv),
		.num   (nq_s3),
		.level (q_lvl)
	);

	hsvrgb_div_d u_div_t (
		.clk   (clk),
		.en    (adv),
		.num   (nt_s3),
		.level (t_lvl)
	);

	always_comb begin
		case (sector_s4)
			hsvrgb_pkg::SEC_0: begin
				r_nx = val_s4; g_nx = t_lvl;  b_nx = p_s4;
			end
			hsvrgb_pkg::SEC_1: begin
				r_nx = q_lvl;  g_nx = val_s4; b_nx = p_s4;
			end
			hsvrgb_pkg::SEC_2: begin
				r_nx = p_s4;   g_nx = val_s4; b_nx = t_lvl;
			end
			hsvrgb_pkg::SEC_3: begin
				r_nx = p_s4;   g_nx = q_lvl;  b_nx = val_s4;
			end
			hsvrgb_pkg::SEC_4: begin
				r_nx = t_lvl;  g_nx = p_s4;   b_nx = val_s4;
			end
			default: begin
				r_nx = val_s4; g_nx = p_s4;   b_nx = q_lvl;
			end
		endcase
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

endmodule

`default_nettype wire

// File: test/tb_hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Self-checking bench for the HSV to RGB converter. Corner colors first, then
// random colors under several sender idle and receiver stall mixes. Each
// accepted request is predicted with exact integer math. Each result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

	import hsvrgb_pkg::*;

	localparam longint unsigned TURN_UNITS  = 23040;	// 360 degrees
	localparam longint unsigned SECTOR_SPAN = 3840;		// 60 degrees
	localparam longint unsigned FULL_DENOM  = 255 * 3840;
	localparam int              DRAIN_WAIT  = 20;		// past the pipeline latency
	localparam int              CYCLE_LIMIT = 200000;

	typedef struct {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} color_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [HUE_W-1:0]  hue;
	logic [CHAN_W-1:0] saturation;
	logic [CHAN_W-1:0] brightness;
	logic              out_valid;
	logic              out_ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	color_t pending_colors[$];
	int     mismatch_count = 0;
	int     cycle_count    = 0;
	int     idle_pct       = 0;
	int     stall_pct      = 0;

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Exact integer HSV to RGB, truncating each channel
	function automatic color_t hsv_to_rgb(logic [HUE_W-1:0] h_in, logic [CHAN_W-1:0] s_in,
			logic [CHAN_W-1:0] v_in);
		longint unsigned h, s, v, f, p, q, t, r, g, b;
		sector_t         sec;
		color_t          c;
		h = h_in;
		s = s_in;
		v = v_in;
		if (s == 0) begin
			c.r = v_in;
			c.g = v_in;
			c.b = v_in;
			return c;
		end
		if (h >= TURN_UNITS)
			h = 0;
		sec = sector_t'(h / SECTOR_SPAN);
		f = h % SECTOR_SPAN;
		p = (v * (255 - s)) / 255;
		q = (v * (FULL_DENOM - s * f)) / FULL_DENOM;
		t = (v * (FULL_DENOM - s * (SECTOR_SPAN - f))) / FULL_DENOM;
		case (sec)
			SEC_0: begin r = v; g = t; b = p; end
			SEC_1: begin r = q; g = v; b = p; end
			SEC_2: begin r = p; g = v; b = t; end
			SEC_3: begin r = p; g = q; b = v; end
			SEC_4: begin r = t; g = p; b = v; end
			default: begin r = v; g = p; b = q; end
		endcase
		c.r = r[CHAN_W-1:0];
		c.g = g[CHAN_W-1:0];
		c.b = b[CHAN_W-1:0];
		return c;
	endfunction

	task automatic report_mismatch(string field, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		mismatch_count++;
	endtask

	// Result checks run before the new request is queued, both off pre-edge values
	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_colors.size() == 0) begin
					$display("[%0t] result with no request outstanding: %0d %0d %0d",
						$realtime, red, green, blue);
					mismatch_count++;
				end else begin
					want = pending_colors.pop_front();
					if (red !== want.r)
						report_mismatch("red", red, want.r);
					if (green !== want.g)
						report_mismatch("green", green, want.g);
					if (blue !== want.b)
						report_mismatch("blue", blue, want.b);
				end
			end
			if (in_valid && in_ready)
				pending_colors.push_back(hsv_to_rgb(hue, saturation, brightness));
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge that accepted the request
	task automatic send_color(logic [HUE_W-1:0] h, logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CHAN_W-1:0] pick_channel();
		int kind;
		kind = $urandom_range(0, 99);
		if (kind < 8)
			return '0;
		if (kind < 16)
			return '1;
		return CHAN_W'($urandom_range(0, 255));
	endfunction

	task automatic send_random_colors(int count);
		logic [HUE_W-1:0] h;
		int               kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 75)
				h = HUE_W'($urandom_range(0, 23039));
			else if (kind < 90)
				h = HUE_W'($urandom_range(23040, 65535));
			else
				h = HUE_W'($urandom_range(0, 6) * 3840 + $urandom_range(0, 2));
			send_color(h, pick_channel(), pick_channel());
		end
	endtask

	task automatic test_corners();
		idle_pct  = 0;
		stall_pct = 0;
		// sector edges, full saturation and value
		send_color(16'd0,     8'd255, 8'd255);
		send_color(16'd3839,  8'd255, 8'd255);
		send_color(16'd3840,  8'd255, 8'd255);
		send_color(16'd7680,  8'd255, 8'd255);
		send_color(16'd11520, 8'd255, 8'd255);
		send_color(16'd15360, 8'd255, 8'd255);
		send_color(16'd19200, 8'd255, 8'd255);
		send_color(16'd23039, 8'd255, 8'd255);
		// hue at or past a full turn wraps to zero
		send_color(16'd23040, 8'd200, 8'd180);
		send_color(16'd23041, 8'd255, 8'd255);
		send_color(16'd65535, 8'd128, 8'd77);
		// grey: no saturation
		send_color(16'd5000,  8'd0,   8'd255);
		send_color(16'd65535, 8'd0,   8'd0);
		send_color(16'd12345, 8'd0,   8'd131);
		// black and near-black
		send_color(16'd9000,  8'd255, 8'd0);
		send_color(16'd1920,  8'd1,   8'd1);
		// mid-sector fractions in each sector
		send_color(16'd1920,  8'd170, 8'd200);
		send_color(16'd5760,  8'd170, 8'd200);
		send_color(16'd9600,  8'd170, 8'd200);
		send_color(16'd13440, 8'd170, 8'd200);
		send_color(16'd17280, 8'd170, 8'd200);
		send_color(16'd21120, 8'd170, 8'd200);
		send_color(16'd1,     8'd1,   8'd255);
		send_color(16'd43690, 8'd85,  8'd170);
		drain_results();
	endtask

	task automatic test_back_to_back();
		idle_pct  = 0;
		stall_pct = 0;
		send_random_colors(200);
		drain_results();
	endtask

	task automatic test_sender_gaps();
		idle_pct  = 64;
		stall_pct = 0;
		send_random_colors(200);
		drain_results();
	endtask

	task automatic test_receiver_stall();
		idle_pct  = 0;
		stall_pct = 64;
		send_random_colors(200);
		drain_results();
	endtask

	task automatic test_mixed_idle();
		idle_pct  = 36;
		stall_pct = 36;
		send_random_colors(100);
		// let the pipe empty completely mid-stream
		drain_results();
		@(posedge clk);
		send_random_colors(100);
		drain_results();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		hue        = '0;
		saturation = '0;
		brightness = '0;
		out_ready  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_back_to_back();
		test_sender_gaps();
		test_receiver_stall();
		test_mixed_idle();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0 && pending_colors.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
